// ===== rtl/core/glq_pkg.sv =====
// shared types and constants for the glyph quad layout core
package glq_pkg;

    localparam int GLQ_GLYPH_COUNT     = 256;
    localparam int GLQ_KERN_LEFT_CODES = 128;
    localparam int GLQ_TEXTURE_BITS    = 12;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 152;
    localparam int GLYPH_W    = 64;

    typedef enum logic [1:0] {
        ACT_LOAD_GLYPH = 2'd0,
        ACT_LOAD_KERN  = 2'd1,
        ACT_START      = 2'd2,
        ACT_CHAR       = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X   = 2'd0,
        CFG_BASELINE_Y = 2'd1,
        CFG_TEX_WIDTH  = 2'd2,
        CFG_TEX_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_DIV,
        ST_HOLD
    } t_state;

endpackage

// ===== rtl/core/glq_mem.sv =====
// glyph metric memory and kerning memory, with a clearing sweep of the kerning memory after reset
module glq_mem #(
    parameter int GLYPH_COUNT     = glq_pkg::GLQ_GLYPH_COUNT,
    parameter int KERN_LEFT_CODES = glq_pkg::GLQ_KERN_LEFT_CODES,
    parameter int GAW             = $clog2(GLYPH_COUNT),
    parameter int KAW             = (KERN_LEFT_CODES > 1 ? $clog2(KERN_LEFT_CODES) : 1) + 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_glyph_we,
    input  logic [GAW-1:0]              i_glyph_addr,
    input  logic [glq_pkg::GLYPH_W-1:0] i_glyph_wdata,
    output logic [glq_pkg::GLYPH_W-1:0] o_glyph_rdata,
    input  logic                        i_kern_we,
    input  logic [KAW-1:0]              i_kern_addr,
    input  logic [7:0]                  i_kern_wdata,
    output logic [7:0]                  o_kern_rdata,
    output logic                        o_clearing
);
    import glq_pkg::*;

    localparam int KDEPTH = KERN_LEFT_CODES * 256;
    localparam logic [KAW-1:0] KLAST = KAW'(KDEPTH - 1);

    logic [GLYPH_W-1:0] r_glyph_mem [GLYPH_COUNT];
    logic [7:0]         r_kern_mem [KDEPTH];
    logic [KAW-1:0]     r_clr_addr;
    logic               r_clearing;
    logic [GLYPH_W-1:0] r_glyph_q;
    logic [7:0]         r_kern_q;
    logic               kern_we;
    logic [KAW-1:0]     kern_addr;
    logic [7:0]         kern_wdata;

    always_comb begin
        kern_we    = r_clearing | i_kern_we;
        kern_addr  = r_clearing ? r_clr_addr : i_kern_addr;
        kern_wdata = r_clearing ? 8'd0 : i_kern_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == KLAST) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_glyph_we) begin
            r_glyph_mem[i_glyph_addr] <= i_glyph_wdata;
        end
        r_glyph_q <= r_glyph_mem[i_glyph_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kern_we) begin
            r_kern_mem[kern_addr] <= kern_wdata;
        end
        r_kern_q <= r_kern_mem[i_kern_addr];
    end

    assign o_glyph_rdata = r_glyph_q;
    assign o_kern_rdata  = r_kern_q;
    assign o_clearing    = r_clearing;

endmodule

// ===== rtl/core/glq_div.sv =====
// bit-serial divider for one texture coordinate, saturating to q1.16
module glq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_num,
    input  logic [12:0] i_den,
    output logic [16:0] o_quot,
    output logic        o_busy
);
    import glq_pkg::*;

    logic [28:0] r_dvd;
    logic [28:0] r_quo;
    logic [12:0] r_rem;
    logic [12:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [13:0] rem_sh;
    logic        ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[28]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd28;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, 16'd0};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[27:0], 1'b0};
            r_rem <= ge ? 13'(rem_sh - {1'b0, r_den}) : rem_sh[12:0];
            r_quo <= {r_quo[27:0], ge};
        end
    end

    assign o_quot = (r_quo[28:17] != 12'd0) ? 17'h1ffff : r_quo[16:0];
    assign o_busy = r_busy;

endmodule

// ===== rtl/core/glyph_quad_layout_core.sv =====
// top level of the glyph quad layout core
// Each lay-out item gives one quad. Load and start items are done as they are taken; a lay-out
// item goes through the glyph and kerning memory reads, the screen edges and pen update, the
// four bit-serial texture coordinate dividers and the load of the output register. The result
// waits in an output register, so the next item is taken while it is pending. After reset the
// kerning memory is cleared one entry a cycle, all KERN_LEFT_CODES * 256 entries (32768 by
// default), before the first item is taken; configuration writes are taken meanwhile.
module glyph_quad_layout_core #(
    parameter int GLYPH_COUNT     = glq_pkg::GLQ_GLYPH_COUNT,
    parameter int KERN_LEFT_CODES = glq_pkg::GLQ_KERN_LEFT_CODES,
    parameter int TEXTURE_BITS    = glq_pkg::GLQ_TEXTURE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // char_code, left_code, tex_x, tex_y, glyph_width, glyph_height, offset_x, offset_y,
    // advance, kern_amount
    input  logic [glq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // screen_left, screen_right, screen_top, screen_bottom, u_left, u_right, v_top, v_bottom
    output logic [glq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import glq_pkg::*;

    localparam int GAW = $clog2(GLYPH_COUNT);
    localparam int KLW = KERN_LEFT_CODES > 1 ? $clog2(KERN_LEFT_CODES) : 1;
    localparam int KAW = KLW + 8;
    localparam int TB_EFF = TEXTURE_BITS < 12 ? TEXTURE_BITS : 12;
    localparam logic [11:0] TEX_MASK = 12'((32'd1 << TB_EFF) - 32'd1);

    logic [15:0] r_origin_x, r_baseline_y;
    logic [12:0] r_tex_w, r_tex_h;
    logic [19:0] r_pen_x;
    logic [7:0]  r_prev;
    logic        r_has_prev;
    logic        r_kern_en;
    logic [7:0]  r_code;
    t_state      r_state, n_state;

    logic [19:0] r_sl, r_sr, r_st, r_sb;
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_action     act;
    logic [7:0]  in_code;
    logic [6:0]  in_left;
    logic        accept, code_ok, left_ok;
    logic        clearing, div_busy, div_start, out_load, st_ready;
    logic [GLYPH_W-1:0] glyph_q;
    logic [7:0]  kern_q;
    logic [KAW-1:0] kern_addr;
    logic [KLW-1:0] kern_left;
    logic [11:0] g_tx, g_ty;
    logic [7:0]  g_w, g_h, g_ox, g_oy, g_adv;
    logic [19:0] kern_ext, sl, st;
    logic [16:0] q_ul, q_ur, q_vt, q_vb;
    logic        b_ul, b_ur, b_vt, b_vb;

    assign act     = t_action'(s_axis_tuser);
    assign in_code = s_axis_tdata[7:0];
    assign in_left = s_axis_tdata[14:8];
    assign accept  = s_axis_tvalid & s_axis_tready;
    assign code_ok = {1'b0, in_code} < 9'(GLYPH_COUNT);
    assign left_ok = {1'b0, in_left} < 8'(KERN_LEFT_CODES);

    always_comb begin
        kern_left = (act == ACT_CHAR) ? r_prev[KLW-1:0] : in_left[KLW-1:0];
        kern_addr = {kern_left, in_code};
    end

    glq_mem #(
        .GLYPH_COUNT    (GLYPH_COUNT),
        .KERN_LEFT_CODES(KERN_LEFT_CODES),
        .GAW            (GAW),
        .KAW            (KAW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_glyph_we   (accept && act == ACT_LOAD_GLYPH && code_ok),
        .i_glyph_addr (in_code[GAW-1:0]),
        .i_glyph_wdata({s_axis_tdata[78:39], s_axis_tdata[38:27] & TEX_MASK,
                        s_axis_tdata[26:15] & TEX_MASK}),
        .o_glyph_rdata(glyph_q),
        .i_kern_we    (accept && act == ACT_LOAD_KERN && left_ok),
        .i_kern_addr  (kern_addr),
        .i_kern_wdata (s_axis_tdata[86:79]),
        .o_kern_rdata (kern_q),
        .o_clearing   (clearing)
    );

    assign g_tx  = glyph_q[11:0];
    assign g_ty  = glyph_q[23:12];
    assign g_w   = glyph_q[31:24];
    assign g_h   = glyph_q[39:32];
    assign g_ox  = glyph_q[47:40];
    assign g_oy  = glyph_q[55:48];
    assign g_adv = glyph_q[63:56];

    always_comb begin
        kern_ext = r_kern_en ? {{12{kern_q[7]}}, kern_q} : 20'd0;
        sl = r_pen_x + {{12{g_ox[7]}}, g_ox} + kern_ext;
        st = {{4{r_baseline_y[15]}}, r_baseline_y} - {{12{g_oy[7]}}, g_oy};
    end

    assign div_start = (r_state == ST_LOOK);

    glq_div u_div_ul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({1'b0, g_tx}), .i_den(r_tex_w), .o_quot(q_ul), .o_busy(b_ul));
    glq_div u_div_ur (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({1'b0, g_tx} + {5'd0, g_w}), .i_den(r_tex_w), .o_quot(q_ur), .o_busy(b_ur));
    glq_div u_div_vt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({1'b0, g_ty}), .i_den(r_tex_h), .o_quot(q_vt), .o_busy(b_vt));
    glq_div u_div_vb (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({1'b0, g_ty} + {5'd0, g_h}), .i_den(r_tex_h), .o_quot(q_vb), .o_busy(b_vb));

    assign div_busy = b_ul | b_ur | b_vt | b_vb;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (!clearing) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && act == ACT_CHAR && code_ok) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_DIV;
            ST_DIV, ST_HOLD: begin
                if (!div_busy) begin
                    n_state = (!r_out_valid || m_axis_tready) ? ST_IDLE : ST_HOLD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        st_ready = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: st_ready = 1'b1;
            ST_DIV, ST_HOLD: out_load = !div_busy && (!r_out_valid || m_axis_tready);
            default: begin
                st_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = st_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_origin_x   <= '0;
            r_baseline_y <= '0;
            r_tex_w      <= 13'd256;
            r_tex_h      <= 13'd256;
            r_pen_x      <= '0;
            r_prev       <= '0;
            r_has_prev   <= 1'b0;
            r_kern_en    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data;
                    CFG_BASELINE_Y: r_baseline_y <= i_cfg_data;
                    CFG_TEX_WIDTH:  r_tex_w      <= i_cfg_data[12:0];
                    CFG_TEX_HEIGHT: r_tex_h      <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (accept && act == ACT_START) begin
                r_pen_x    <= {{4{r_origin_x[15]}}, r_origin_x};
                r_prev     <= '0;
                r_has_prev <= 1'b0;
            end
            if (accept && act == ACT_CHAR) begin
                r_kern_en <= r_has_prev && !r_prev[7] && ({1'b0, r_prev} < 9'(KERN_LEFT_CODES));
            end
            if (r_state == ST_LOOK) begin
                r_pen_x    <= r_pen_x + {12'd0, g_adv} + kern_ext;
                r_prev     <= r_code;
                r_has_prev <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= in_code;
        end
        if (r_state == ST_LOOK) begin
            r_sl <= sl;
            r_sr <= sl + {12'd0, g_w};
            r_st <= st;
            r_sb <= st - {12'd0, g_h};
        end
        if (out_load) begin
            r_out_data <= {4'd0, q_vb, q_vt, q_ur, q_ul, r_sb, r_st, r_sr, r_sl};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== tb/tb.sv =====
// testbench for the glyph quad layout core: predicted quads checked against the stream output
`timescale 1ns / 100ps

module tb;
    import glq_pkg::*;

    localparam int LIMIT  = 3000000;
    localparam int SETTLE = 48;

    typedef struct packed {
        logic [16:0] v_bottom;
        logic [16:0] v_top;
        logic [16:0] u_right;
        logic [16:0] u_left;
        logic [19:0] screen_bottom;
        logic [19:0] screen_top;
        logic [19:0] screen_right;
        logic [19:0] screen_left;
    } t_quad;

    typedef struct {
        logic [11:0] tx, ty;
        logic [7:0]  w, h, ox, oy, adv;
    } t_glyph;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [15:0]           i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    glyph_quad_layout_core uut (.*);

    // layout state mirrored from the block
    t_glyph      glyph_mem [256];
    logic [7:0]  kern_mem [32768];
    bit          glyph_loaded [256];
    logic [19:0] pen_x;
    logic [7:0]  prev_code;
    bit          has_prev;
    logic [15:0] origin_x, baseline_y;
    logic [12:0] tex_w, tex_h;

    t_quad       quad_queue[$];
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("glyph_quad_layout_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_quad got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[147:0];
            if (quad_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quad %h", got);
            end else begin
                want = quad_queue.pop_front();
                if (got.screen_left !== want.screen_left || got.screen_right !== want.screen_right
                    || got.screen_top !== want.screen_top
                    || got.screen_bottom !== want.screen_bottom
                    || got.u_left !== want.u_left || got.u_right !== want.u_right
                    || got.v_top !== want.v_top || got.v_bottom !== want.v_bottom) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("quad mismatch: exp l%h r%h t%h b%h ul%h ur%h vt%h vb%h",
                                 want.screen_left, want.screen_right, want.screen_top,
                                 want.screen_bottom, want.u_left, want.u_right, want.v_top,
                                 want.v_bottom, "\n              got l%h r%h t%h b%h ul%h ur%h vt%h vb%h",
                                 got.screen_left, got.screen_right, got.screen_top,
                                 got.screen_bottom, got.u_left, got.u_right, got.v_top,
                                 got.v_bottom);
                end
            end
        end
    end

    function automatic logic [16:0] tex_coord(logic [12:0] texel, logic [12:0] size);
        logic [63:0] q;
        if (size == 0)
            return 17'h1FFFF;
        q = {35'd0, texel, 16'd0} / size;
        return (q > 64'd131071) ? 17'h1FFFF : q[16:0];
    endfunction

    function automatic logic [19:0] sx8(logic [7:0] v);
        return {{12{v[7]}}, v};
    endfunction

    // update mirrored state and queue the quad a lay-out item yields
    task automatic layout_step(t_action act, logic [IN_DATA_W-1:0] d);
        logic [7:0]  code;
        logic [6:0]  left;
        logic [19:0] kern;
        t_glyph      g;
        t_quad       q;
        code = d[7:0];
        left = d[14:8];
        case (act)
            ACT_LOAD_GLYPH: begin
                g.tx = d[26:15]; g.ty = d[38:27]; g.w = d[46:39]; g.h = d[54:47];
                g.ox = d[62:55]; g.oy = d[70:63]; g.adv = d[78:71];
                glyph_mem[code] = g;
                glyph_loaded[code] = 1'b1;
            end
            ACT_LOAD_KERN: kern_mem[{left, code}] = d[86:79];
            ACT_START: begin
                pen_x = {{4{origin_x[15]}}, origin_x};
                has_prev = 1'b0;
                prev_code = '0;
            end
            default: begin
                g = glyph_mem[code];
                kern = (has_prev && !prev_code[7]) ? sx8(kern_mem[{prev_code[6:0], code}]) : '0;
                q.screen_left   = pen_x + sx8(g.ox) + kern;
                q.screen_right  = q.screen_left + {12'd0, g.w};
                q.screen_top    = {{4{baseline_y[15]}}, baseline_y} - sx8(g.oy);
                q.screen_bottom = q.screen_top - {12'd0, g.h};
                q.u_left   = tex_coord({1'b0, g.tx}, tex_w);
                q.u_right  = tex_coord({1'b0, g.tx} + g.w, tex_w);
                q.v_top    = tex_coord({1'b0, g.ty}, tex_h);
                q.v_bottom = tex_coord({1'b0, g.ty} + g.h, tex_h);
                quad_queue.push_back(q);
                pen_x = pen_x + {12'd0, g.adv} + kern;
                prev_code = code;
                has_prev = 1'b1;
            end
        endcase
    endtask

    task automatic send_item(t_action act, logic [IN_DATA_W-1:0] d);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        layout_step(act, d);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [7:0] code, logic [6:0] left,
            logic [11:0] tx, logic [11:0] ty, logic [7:0] w, logic [7:0] h, logic [7:0] ox,
            logic [7:0] oy, logic [7:0] adv, logic [7:0] kern);
        return {1'b0, kern, adv, oy, ox, h, w, ty, tx, left, code};
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:   origin_x = val;
            CFG_BASELINE_Y: baseline_y = val;
            CFG_TEX_WIDTH:  tex_w = val[12:0];
            default:        tex_h = val[12:0];
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (quad_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] ox, logic [15:0] by, logic [15:0] tw,
                              logic [15:0] th);
        drain();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_BASELINE_Y, by);
        write_reg(CFG_TEX_WIDTH, tw);
        write_reg(CFG_TEX_HEIGHT, th);
    endtask

    function automatic logic [IN_DATA_W-1:0] rand_glyph(logic [7:0] code);
        return pack_item(code, 7'($urandom), 12'($urandom), 12'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endfunction

    task automatic test_directed();
        send_item(ACT_LOAD_GLYPH, pack_item(8'd0, 7'd0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF,
                                            8'h80, 8'h7F, 8'hFF, 8'h00));
        send_item(ACT_LOAD_GLYPH, pack_item(8'd255, 7'h7F, 12'd0, 12'd0, 8'd0, 8'd0,
                                            8'h7F, 8'h80, 8'd0, 8'hFF));
        send_item(ACT_LOAD_GLYPH, pack_item(8'd1, 7'd0, 12'd16, 12'd32, 8'd8, 8'd12,
                                            8'd1, 8'd10, 8'd9, 8'd0));
        send_item(ACT_LOAD_GLYPH, pack_item(8'd2, 7'd0, 12'd100, 12'd200, 8'd7, 8'd9,
                                            8'hFE, 8'd8, 8'd8, 8'd0));
        send_item(ACT_LOAD_GLYPH, pack_item(8'd128, 7'd0, 12'd64, 12'd64, 8'd5, 8'd5,
                                            8'd0, 8'd0, 8'd6, 8'd0));
        send_item(ACT_LOAD_KERN, pack_item(8'd2, 7'd1, 0, 0, 0, 0, 0, 0, 0, 8'h80));
        send_item(ACT_LOAD_KERN, pack_item(8'd255, 7'd0, 0, 0, 0, 0, 0, 0, 0, 8'h7F));
        send_item(ACT_LOAD_KERN, pack_item(8'd2, 7'd127, 0, 0, 0, 0, 0, 0, 0, 8'd5));
        send_item(ACT_START, '0);
        send_item(ACT_CHAR, pack_item(8'd1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(ACT_CHAR, pack_item(8'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(ACT_CHAR, pack_item(8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(ACT_CHAR, pack_item(8'd255, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(ACT_CHAR, pack_item(8'd128, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(ACT_CHAR, pack_item(8'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(ACT_START, '0);
        send_item(ACT_CHAR, pack_item(8'd2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // five glyphs in a row with the widest advance
        repeat (5) send_item(ACT_CHAR, pack_item(8'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(int count);
        int          pick;
        logic [7:0]  code;
        logic [7:0]  loaded_codes[$];
        for (int c = 0; c < 256; c++)
            if (glyph_loaded[c]) loaded_codes.push_back(8'(c));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                code = ($urandom_range(1)) ? 8'($urandom_range(15)) : 8'($urandom);
                send_item(ACT_LOAD_GLYPH, rand_glyph(code));
                loaded_codes.push_back(code);
            end else if (pick < 22) begin
                if ($urandom_range(3) != 0)
                    send_item(ACT_LOAD_KERN, pack_item(8'($urandom_range(15)),
                              7'($urandom_range(15)), 0, 0, 0, 0, 0, 0, 0, 8'($urandom)));
                else
                    send_item(ACT_LOAD_KERN, rand_glyph(8'($urandom)));
            end else if (pick < 30) begin
                send_item(ACT_START, rand_glyph(8'($urandom)));
            end else begin
                code = ($urandom_range(3) != 0) ? 8'($urandom_range(15))
                       : loaded_codes[$urandom_range(loaded_codes.size() - 1)];
                send_item(ACT_CHAR, pack_item(code, 7'($urandom), 12'($urandom), 12'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom)));
            end
        end
    endtask

    task automatic test_backpressure();
        recv_stall_pct = 0;
        send_idle_pct  = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            test_random(40);
        join
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_LOAD_GLYPH;
        m_axis_tready = 1'b0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        cycles = 0;
        pen_x = '0;
        prev_code = '0;
        has_prev = 1'b0;
        origin_x = '0;
        baseline_y = '0;
        tex_w = 13'd256;
        tex_h = 13'd256;
        foreach (kern_mem[k]) kern_mem[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        for (int c = 3; c < 16; c++)
            send_item(ACT_LOAD_GLYPH, rand_glyph(8'(c)));
        test_random(150);

        set_config(16'h8000, 16'h7FFF, 16'd1, 16'd4096);
        send_idle_pct = 66;
        test_random(150);

        set_config(16'h7FFF, 16'h8000, 16'd4096, 16'd1);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        test_random(150);

        set_config(16'($urandom), 16'($urandom), 16'd0, 16'h1FFF);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        test_random(150);

        set_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 4096)),
                   16'($urandom_range(1, 4096)));
        test_backpressure();
        send_idle_pct = 24;
        recv_stall_pct = 24;
        test_random(100);

        drain();
        if (mismatches == 0)
            $display("glyph_quad_layout_core regression: pass");
        else
            $display("glyph_quad_layout_core regression: fail");
        $finish;
    end
endmodule
